// ----- design/lobl_pkg.sv -----
// ----------------------------------------------------------------------------
// lobl_pkg
// Shared types, codes and default sizes for the limit order book levels unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lobl_pkg;

    localparam int DEF_LEVELS = 1024;
    localparam int DEF_ORDERS = 4096;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_CANCEL = 3'd1;
    localparam logic [2:0] OP_MODIFY = 3'd2;
    localparam logic [2:0] OP_QUERY  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_WINDOW  = 3'd3;
    localparam logic [2:0] ST_ID_BIG  = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ORD,
        S_QRY,
        S_LVL,
        S_INS_RD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] ord_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] top_bid;
        logic [47:0] bid_qty;
        logic [31:0] top_ask;
        logic [47:0] ask_qty;
        logic [31:0] spread;
        logic [47:0] level_qty;
        logic [31:0] orders_added;
    } out_t;

endpackage

`default_nettype wire

// ----- design/limit_order_book_levels_unit.sv -----
// ----------------------------------------------------------------------------
// limit_order_book_levels_unit
// Order table and per-side price level totals held in synchronous memories.
// ----------------------------------------------------------------------------
//  channel | signals                    | direction
//  in      | in_valid, in_ready, in_data | order event beat in
//  out     | out_valid, out_ready, out_data | quote beat out
//  cfg     | cfg_we, cfg_wdata          | price_base write
//
//  An event is decoded; a query then reads its level, and an add, cancel or modify
//  reads the order table and updates one level, two for a modify. An event that
//  is rejected at decode or at the order read goes straight to its quote. A cancel
//  or modify that empties the best level of its side adds a rescan that steps one
//  level at a time, at most LEVELS - 1 levels. After reset and after a clear event
//  a clearing pass over both memories runs with in_ready low.
//  A finished quote waits in the output register while the next event is taken.
`default_nettype none

module limit_order_book_levels_unit
    import lobl_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS,
    parameter int ORDERS = DEF_ORDERS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_t             out_data,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    localparam int LW    = $clog2(LEVELS);
    localparam int OW    = $clog2(ORDERS);
    localparam int CNTW  = $clog2(ORDERS + 1);
    localparam int LDEP  = 2 << LW;
    localparam int CLR_N = (ORDERS > LDEP) ? ORDERS : LDEP;
    localparam int CW    = $clog2(CLR_N);
    localparam int OWD   = 2 + LW + 32;
    localparam int LWD   = CNTW + 48;

    state_t state_reg, state_next;

    in_t              item_reg, item_next;
    logic [CW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             clear_op_reg, clear_op_next;
    logic [2:0]       status_reg, status_next;
    logic [47:0]      lvl_qty_reg, lvl_qty_next;
    logic [31:0]      add_cnt_reg, add_cnt_next;
    logic [31:0]      price_base_reg;
    logic             bb_valid_reg, bb_valid_next, ba_valid_reg, ba_valid_next;
    logic [LW-1:0]    bb_lvl_reg, bb_lvl_next, ba_lvl_reg, ba_lvl_next;
    logic [47:0]      bb_qty_reg, bb_qty_next, ba_qty_reg, ba_qty_next;
    logic             lvl_side_reg, lvl_side_next;
    logic [LW-1:0]    lvl_off_reg, lvl_off_next;
    logic [31:0]      lvl_op_qty_reg, lvl_op_qty_next;
    logic             lvl_ins_reg, lvl_ins_next;
    logic             pend_reg, pend_next;
    logic             ins_side_reg, ins_side_next;
    logic [LW-1:0]    ins_off_reg, ins_off_next;
    logic [31:0]      ins_qty_reg, ins_qty_next;
    logic             scan_side_reg, scan_side_next;
    logic [LW-1:0]    scan_off_reg, scan_off_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_data_reg, out_data_next;

    logic [OWD-1:0]   ord_mem [ORDERS];
    logic [LWD-1:0]   lvl_mem [LDEP];
    logic [OWD-1:0]   ord_rdata_reg;
    logic [LWD-1:0]   lvl_rdata_reg;

    logic             ord_we;
    logic [OW-1:0]    ord_waddr;
    logic [OWD-1:0]   ord_wdata;
    logic             lvl_we;
    logic [LW:0]      lvl_waddr, lvl_raddr;
    logic [LWD-1:0]   lvl_wdata;

    logic [32:0]      diff;
    logic             win_ok, id_ok, clr_last;
    logic [LW-1:0]    off;
    logic             o_valid, o_side;
    logic [LW-1:0]    o_lvl;
    logic [31:0]      o_qty;
    logic [CNTW-1:0]  l_cnt, new_cnt;
    logic [47:0]      l_tot, new_tot;
    logic             empties_best, at_edge, scan_end;
    logic [31:0]      bid_px, ask_px;

    always_comb
    begin
        diff      = {1'b0, item_reg.price} - {1'b0, price_base_reg};
        win_ok    = !diff[32] && (diff[31:0] < 32'(LEVELS));
        off       = diff[LW-1:0];
        id_ok     = {1'b0, item_reg.ord_id} < 17'(ORDERS);
        clr_last  = clr_cnt_reg == CW'(CLR_N - 1);
        o_valid   = ord_rdata_reg[OWD-1];
        o_side    = ord_rdata_reg[OWD-2];
        o_lvl     = ord_rdata_reg[32 +: LW];
        o_qty     = ord_rdata_reg[31:0];
        l_cnt     = lvl_rdata_reg[48 +: CNTW];
        l_tot     = lvl_rdata_reg[47:0];
        if (lvl_ins_reg)
        begin
            new_cnt = l_cnt + CNTW'(1);
            new_tot = l_tot + {16'd0, lvl_op_qty_reg};
        end
        else
        begin
            new_cnt = (l_cnt != '0) ? l_cnt - CNTW'(1) : '0;
            new_tot = l_tot - {16'd0, lvl_op_qty_reg};
        end
        if (lvl_side_reg)
        begin
            empties_best = (new_cnt == '0) && ba_valid_reg && (lvl_off_reg == ba_lvl_reg);
            at_edge      = lvl_off_reg == LW'(LEVELS - 1);
        end
        else
        begin
            empties_best = (new_cnt == '0) && bb_valid_reg && (lvl_off_reg == bb_lvl_reg);
            at_edge      = lvl_off_reg == '0;
        end
        scan_end = scan_side_reg ? (scan_off_reg == LW'(LEVELS - 1)) : (scan_off_reg == '0);
        bid_px   = price_base_reg + 32'(bb_lvl_reg);
        ask_px   = price_base_reg + 32'(ba_lvl_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_last)
                begin
                    state_next = clear_op_reg ? S_FIN : S_IDLE;
                end
            S_IDLE:
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            S_DECODE:
                unique case (item_reg.opcode) inside
                    OP_ADD, OP_CANCEL, OP_MODIFY: state_next = id_ok ? S_ORD : S_FIN;
                    OP_QUERY:                     state_next = win_ok ? S_QRY : S_FIN;
                    OP_CLEAR:                     state_next = S_CLEAR;
                    default:                      state_next = S_FIN;
                endcase
            S_ORD:
                unique case (item_reg.opcode)
                    OP_ADD:    state_next = (!o_valid && win_ok) ? S_LVL : S_FIN;
                    OP_CANCEL: state_next = o_valid ? S_LVL : S_FIN;
                    default:   state_next = (o_valid && win_ok) ? S_LVL : S_FIN;
                endcase
            S_QRY:
                state_next = S_FIN;
            S_LVL:
                if (empties_best && !at_edge)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = pend_reg ? S_INS_RD : S_FIN;
                end
            S_INS_RD:
                state_next = S_LVL;
            S_SCAN_RD:
                state_next = S_SCAN_CHK;
            S_SCAN_CHK:
                if ((l_cnt != '0) || scan_end)
                begin
                    state_next = pend_reg ? S_INS_RD : S_FIN;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            S_FIN:
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        item_next       = item_reg;
        clr_cnt_next    = clr_cnt_reg;
        clear_op_next   = clear_op_reg;
        status_next     = status_reg;
        lvl_qty_next    = lvl_qty_reg;
        add_cnt_next    = add_cnt_reg;
        bb_valid_next   = bb_valid_reg;
        bb_lvl_next     = bb_lvl_reg;
        bb_qty_next     = bb_qty_reg;
        ba_valid_next   = ba_valid_reg;
        ba_lvl_next     = ba_lvl_reg;
        ba_qty_next     = ba_qty_reg;
        lvl_side_next   = lvl_side_reg;
        lvl_off_next    = lvl_off_reg;
        lvl_op_qty_next = lvl_op_qty_reg;
        lvl_ins_next    = lvl_ins_reg;
        pend_next       = pend_reg;
        ins_side_next   = ins_side_reg;
        ins_off_next    = ins_off_reg;
        ins_qty_next    = ins_qty_reg;
        scan_side_next  = scan_side_reg;
        scan_off_next   = scan_off_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        ord_we          = 1'b0;
        ord_waddr       = item_reg.ord_id[OW-1:0];
        ord_wdata       = '0;
        lvl_we          = 1'b0;
        lvl_waddr       = {lvl_side_reg, lvl_off_reg};
        lvl_wdata       = {new_cnt, new_tot};
        lvl_raddr       = {item_reg.side, off};
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next  = clr_last ? '0 : clr_cnt_reg + CW'(1);
                bb_valid_next = 1'b0;
                ba_valid_next = 1'b0;
                add_cnt_next  = '0;
                pend_next     = 1'b0;
                ord_we        = {1'b0, clr_cnt_reg} < (CW + 1)'(ORDERS);
                ord_waddr     = clr_cnt_reg[OW-1:0];
                lvl_we        = {1'b0, clr_cnt_reg} < (CW + 1)'(LDEP);
                lvl_waddr     = clr_cnt_reg[LW:0];
                lvl_wdata     = '0;
            end
            S_IDLE:
                if (in_valid)
                begin
                    item_next     = in_data;
                    status_next   = ST_OK;
                    lvl_qty_next  = '0;
                    clear_op_next = 1'b0;
                    pend_next     = 1'b0;
                end
            S_DECODE:
                unique case (item_reg.opcode) inside
                    OP_ADD, OP_CANCEL, OP_MODIFY:
                        if (!id_ok)
                        begin
                            status_next = ST_ID_BIG;
                        end
                    OP_QUERY:
                        if (!win_ok)
                        begin
                            status_next = ST_WINDOW;
                        end
                    OP_CLEAR:
                        clear_op_next = 1'b1;
                    default:
                        status_next = ST_OK;
                endcase
            S_ORD:
                unique case (item_reg.opcode)
                    OP_ADD:
                        if (o_valid)
                        begin
                            status_next = ST_PRESENT;
                        end
                        else if (!win_ok)
                        begin
                            status_next = ST_WINDOW;
                        end
                        else
                        begin
                            ord_we          = 1'b1;
                            ord_wdata       = {1'b1, item_reg.side, off, item_reg.quantity};
                            lvl_raddr       = {item_reg.side, off};
                            lvl_side_next   = item_reg.side;
                            lvl_off_next    = off;
                            lvl_op_qty_next = item_reg.quantity;
                            lvl_ins_next    = 1'b1;
                            add_cnt_next    = add_cnt_reg + 32'd1;
                        end
                    default:
                        if (!o_valid)
                        begin
                            status_next = ST_ABSENT;
                        end
                        else if ((item_reg.opcode == OP_MODIFY) && !win_ok)
                        begin
                            status_next = ST_WINDOW;
                        end
                        else
                        begin
                            ord_we          = 1'b1;
                            lvl_raddr       = {o_side, o_lvl};
                            lvl_side_next   = o_side;
                            lvl_off_next    = o_lvl;
                            lvl_op_qty_next = o_qty;
                            lvl_ins_next    = 1'b0;
                            if (item_reg.opcode == OP_MODIFY)
                            begin
                                ord_wdata     = {1'b1, o_side, off, item_reg.quantity};
                                pend_next     = 1'b1;
                                ins_side_next = o_side;
                                ins_off_next  = off;
                                ins_qty_next  = item_reg.quantity;
                            end
                            else
                            begin
                                ord_wdata = {1'b0, o_side, o_lvl, o_qty};
                            end
                        end
                endcase
            S_QRY:
                lvl_qty_next = l_tot;
            S_LVL:
            begin
                lvl_we = 1'b1;
                if (lvl_side_reg)
                begin
                    if (new_cnt != '0)
                    begin
                        if (!ba_valid_reg || (lvl_off_reg < ba_lvl_reg))
                        begin
                            ba_valid_next = 1'b1;
                            ba_lvl_next   = lvl_off_reg;
                            ba_qty_next   = new_tot;
                        end
                        else if (lvl_off_reg == ba_lvl_reg)
                        begin
                            ba_qty_next = new_tot;
                        end
                    end
                    else if (empties_best)
                    begin
                        ba_valid_next = 1'b0;
                    end
                end
                else
                begin
                    if (new_cnt != '0)
                    begin
                        if (!bb_valid_reg || (lvl_off_reg > bb_lvl_reg))
                        begin
                            bb_valid_next = 1'b1;
                            bb_lvl_next   = lvl_off_reg;
                            bb_qty_next   = new_tot;
                        end
                        else if (lvl_off_reg == bb_lvl_reg)
                        begin
                            bb_qty_next = new_tot;
                        end
                    end
                    else if (empties_best)
                    begin
                        bb_valid_next = 1'b0;
                    end
                end
                scan_side_next = lvl_side_reg;
                scan_off_next  = lvl_side_reg ? lvl_off_reg + LW'(1) : lvl_off_reg - LW'(1);
            end
            S_INS_RD:
            begin
                lvl_raddr       = {ins_side_reg, ins_off_reg};
                lvl_side_next   = ins_side_reg;
                lvl_off_next    = ins_off_reg;
                lvl_op_qty_next = ins_qty_reg;
                lvl_ins_next    = 1'b1;
                pend_next       = 1'b0;
            end
            S_SCAN_RD:
                lvl_raddr = {scan_side_reg, scan_off_reg};
            S_SCAN_CHK:
                if (l_cnt != '0)
                begin
                    if (scan_side_reg)
                    begin
                        ba_valid_next = 1'b1;
                        ba_lvl_next   = scan_off_reg;
                        ba_qty_next   = l_tot;
                    end
                    else
                    begin
                        bb_valid_next = 1'b1;
                        bb_lvl_next   = scan_off_reg;
                        bb_qty_next   = l_tot;
                    end
                end
                else if (!scan_end)
                begin
                    scan_off_next = scan_side_reg ? scan_off_reg + LW'(1)
                                                  : scan_off_reg - LW'(1);
                end
            S_FIN:
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = status_reg;
                    out_data_next.top_bid       = bb_valid_reg ? bid_px : 32'd0;
                    out_data_next.bid_qty       = bb_valid_reg ? bb_qty_reg : 48'd0;
                    out_data_next.top_ask       = ba_valid_reg ? ask_px : 32'hFFFF_FFFF;
                    out_data_next.ask_qty       = ba_valid_reg ? ba_qty_reg : 48'd0;
                    out_data_next.spread        = (bb_valid_reg && ba_valid_reg)
                                                  ? ask_px - bid_px : 32'hFFFF_FFFF;
                    out_data_next.level_qty     = lvl_qty_reg;
                    out_data_next.orders_added  = add_cnt_reg;
                end
            default:
                out_valid_next = out_valid_reg && !out_ready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            clear_op_reg   <= 1'b0;
            add_cnt_reg    <= '0;
            price_base_reg <= '0;
            bb_valid_reg   <= 1'b0;
            ba_valid_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clear_op_reg  <= clear_op_next;
            add_cnt_reg   <= add_cnt_next;
            bb_valid_reg  <= bb_valid_next;
            ba_valid_reg  <= ba_valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                price_base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        status_reg     <= status_next;
        lvl_qty_reg    <= lvl_qty_next;
        bb_lvl_reg     <= bb_lvl_next;
        bb_qty_reg     <= bb_qty_next;
        ba_lvl_reg     <= ba_lvl_next;
        ba_qty_reg     <= ba_qty_next;
        lvl_side_reg   <= lvl_side_next;
        lvl_off_reg    <= lvl_off_next;
        lvl_op_qty_reg <= lvl_op_qty_next;
        lvl_ins_reg    <= lvl_ins_next;
        ins_side_reg   <= ins_side_next;
        ins_off_reg    <= ins_off_next;
        ins_qty_reg    <= ins_qty_next;
        scan_side_reg  <= scan_side_next;
        scan_off_reg   <= scan_off_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rdata_reg <= ord_mem[item_reg.ord_id[OW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        lvl_rdata_reg <= lvl_mem[lvl_raddr];
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // A resting order always has its level counted, so a removal never sees an empty level.
    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LVL && !lvl_ins_reg) |-> (l_cnt != '0))
        else $error("level removal found an empty level");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted beat not decoded");

    a_scan_bid_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN_RD || state_reg == S_SCAN_CHK) && !scan_side_reg)
        |-> !bb_valid_reg)
        else $error("bid rescan while a best bid is held");

    a_scan_ask_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN_RD || state_reg == S_SCAN_CHK) && scan_side_reg)
        |-> !ba_valid_reg)
        else $error("ask rescan while a best ask is held");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/lobl_book_checker.sv -----
// ----------------------------------------------------------------------------
// lobl_book_checker
// Watches the event and quote channels of the order book levels unit, keeps
// its own copy of the order table and level totals, predicts each quote and
// compares every quote beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lobl_book_checker
    import lobl_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS,
    parameter int ORDERS = DEF_ORDERS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire in_t         in_data,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire out_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    output int               fail_count,
    output int               quotes_pending
);

    logic [31:0] base_tick;
    bit          live [ORDERS];
    bit          live_side [ORDERS];
    int          live_level [ORDERS];
    logic [31:0] live_qty [ORDERS];
    logic [47:0] lvl_sum [2*LEVELS];
    int          lvl_cnt [2*LEVELS];
    logic [31:0] adds_seen;
    out_t        quote_q [$];

    assign quotes_pending = quote_q.size();

    function automatic int tick_offset(logic [31:0] p);
        logic [32:0] d;
        d = {1'b0, p} - {1'b0, base_tick};
        if (p < base_tick || d >= LEVELS)
            return -1;
        return int'(d);
    endfunction

    function automatic void wipe_book();
        for (int i = 0; i < ORDERS; i++)
            live[i] = 0;
        for (int k = 0; k < 2*LEVELS; k++)
        begin
            lvl_sum[k] = '0;
            lvl_cnt[k] = 0;
        end
        adds_seen = '0;
    endfunction

    function automatic void level_move(int k, logic [31:0] q, bit add);
        if (add)
        begin
            lvl_sum[k] = lvl_sum[k] + {16'd0, q};
            lvl_cnt[k]++;
        end
        else
        begin
            lvl_sum[k] = lvl_sum[k] - {16'd0, q};
            if (lvl_cnt[k] > 0)
                lvl_cnt[k]--;
        end
    endfunction

    function automatic out_t quote_after(in_t ev);
        out_t r;
        int off;
        int id;
        int bb;
        int ba;
        r = '0;
        r.status = ST_OK;
        off = tick_offset(ev.price);
        id = ev.ord_id;
        if (ev.opcode == OP_ADD || ev.opcode == OP_CANCEL || ev.opcode == OP_MODIFY)
        begin
            if (id >= ORDERS)
                r.status = ST_ID_BIG;
            else if (ev.opcode == OP_ADD)
            begin
                if (live[id])
                    r.status = ST_PRESENT;
                else if (off < 0)
                    r.status = ST_WINDOW;
                else
                begin
                    live[id] = 1;
                    live_side[id] = ev.side;
                    live_level[id] = off;
                    live_qty[id] = ev.quantity;
                    level_move(ev.side * LEVELS + off, ev.quantity, 1);
                    adds_seen++;
                end
            end
            else if (!live[id])
                r.status = ST_ABSENT;
            else if (ev.opcode == OP_CANCEL)
            begin
                level_move(live_side[id] * LEVELS + live_level[id], live_qty[id], 0);
                live[id] = 0;
            end
            else if (off < 0)
                r.status = ST_WINDOW;
            else
            begin
                level_move(live_side[id] * LEVELS + live_level[id], live_qty[id], 0);
                live_level[id] = off;
                live_qty[id] = ev.quantity;
                level_move(live_side[id] * LEVELS + off, ev.quantity, 1);
            end
        end
        else if (ev.opcode == OP_QUERY)
        begin
            if (off < 0)
                r.status = ST_WINDOW;
            else
                r.level_qty = lvl_sum[ev.side * LEVELS + off];
        end
        else if (ev.opcode == OP_CLEAR)
            wipe_book();
        bb = -1;
        ba = -1;
        for (int k = LEVELS - 1; k >= 0; k--)
            if (bb < 0 && lvl_cnt[k] != 0)
                bb = k;
        for (int k = 0; k < LEVELS; k++)
            if (ba < 0 && lvl_cnt[LEVELS + k] != 0)
                ba = k;
        r.top_ask = '1;
        r.spread = '1;
        if (bb >= 0)
        begin
            r.top_bid = base_tick + 32'(bb);
            r.bid_qty = lvl_sum[bb];
        end
        if (ba >= 0)
        begin
            r.top_ask = base_tick + 32'(ba);
            r.ask_qty = lvl_sum[LEVELS + ba];
        end
        if (bb >= 0 && ba >= 0)
            r.spread = r.top_ask - r.top_bid;
        r.orders_added = adds_seen;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("quote mismatch on %s: got %0h, expected %0h", what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        base_tick = '0;
        wipe_book();
    end

    always @(posedge clk)
    begin
        out_t w;
        if (rst_n)
        begin
            if (cfg_we)
                base_tick <= cfg_wdata;
            if (in_valid && in_ready)
                quote_q.insert(quote_q.size(), quote_after(in_data));
            if (out_valid && out_ready)
            begin
                if (quote_q.size() == 0)
                    report_mismatch("unexpected beat", 0, 0);
                else
                begin
                    w = quote_q.pop_front();
                    if (out_data.status != w.status)
                        report_mismatch("status", out_data.status, w.status);
                    if (out_data.top_bid != w.top_bid)
                        report_mismatch("top_bid", out_data.top_bid, w.top_bid);
                    if (out_data.bid_qty != w.bid_qty)
                        report_mismatch("bid_qty", out_data.bid_qty, w.bid_qty);
                    if (out_data.top_ask != w.top_ask)
                        report_mismatch("top_ask", out_data.top_ask, w.top_ask);
                    if (out_data.ask_qty != w.ask_qty)
                        report_mismatch("ask_qty", out_data.ask_qty, w.ask_qty);
                    if (out_data.spread != w.spread)
                        report_mismatch("spread", out_data.spread, w.spread);
                    if (out_data.level_qty != w.level_qty)
                        report_mismatch("level_qty", out_data.level_qty, w.level_qty);
                    if (out_data.orders_added != w.orders_added)
                        report_mismatch("orders_added", out_data.orders_added,
                                        w.orders_added);
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_limit_order_book_levels_unit.sv -----
// ----------------------------------------------------------------------------
// tb_limit_order_book_levels_unit
// Drives order events into the order book levels unit under random gaps and
// stalls, moves the price window between phases, and reports the verdict
// from the checker's failure count and its count of pending quotes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_limit_order_book_levels_unit;
    import lobl_pkg::*;

    localparam int LEVELS = DEF_LEVELS;
    localparam int ORDERS = DEF_ORDERS;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          fail_count;
    int          quotes_pending;
    logic [31:0] base_now;
    bit          hold_off;

    limit_order_book_levels_unit #(.LEVELS(LEVELS), .ORDERS(ORDERS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    lobl_book_checker #(.LEVELS(LEVELS), .ORDERS(ORDERS)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .quotes_pending(quotes_pending)
    );

    initial clk = 0;
    always #6 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 0;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            else
                out_ready <= (gap_len() == 0);
        end
    end

    task automatic send_event(logic [2:0] op, logic [15:0] id, bit sd, logic [31:0] p,
                              logic [31:0] q);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_data <= '{opcode: op, ord_id: id, side: sd, price: p, quantity: q};
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic set_base(logic [31:0] b);
        in_valid <= 0;
        while (quotes_pending != 0)
            @(posedge clk);
        repeat (2*LEVELS*2 + 50) @(posedge clk);
        cfg_wdata <= b;
        cfg_we <= 1;
        @(posedge clk);
        cfg_we <= 0;
        base_now = b;
    endtask

    function automatic logic [31:0] rand_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return base_now + $urandom_range(0, LEVELS - 1);
        if (r < 90)
            return base_now + LEVELS - 1 - $urandom_range(0, 3);
        if (r < 95)
            return base_now + LEVELS + $urandom_range(0, 5);
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_qty();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        if ($urandom_range(0, 19) == 0)
            return '1;
        return $urandom_range(0, 1000);
    endfunction

    task automatic random_phase(int n, int id_span);
        int r;
        logic [2:0] op;
        logic [15:0] id;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                op = OP_ADD;
            else if (r < 60)
                op = OP_CANCEL;
            else if (r < 78)
                op = OP_MODIFY;
            else if (r < 96)
                op = OP_QUERY;
            else if (r < 97)
                op = OP_CLEAR;
            else
                op = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 29) == 0)
                id = 16'($urandom);
            else
                id = 16'($urandom_range(0, id_span - 1));
            send_event(op, id, 1'($urandom_range(0, 1)), rand_price(), rand_qty());
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_we = 0;
        cfg_wdata = '0;
        base_now = '0;
        hold_off = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: price zero bid, edges of window, checks in order, clear.
        send_event(OP_ADD, 0, 0, 0, 32'hFFFF_FFFF);
        send_event(OP_ADD, 1, 0, 0, 32'hFFFF_FFFF);
        send_event(OP_ADD, 2, 1, LEVELS - 1, 0);
        send_event(OP_ADD, 2, 1, 5, 7);
        send_event(OP_ADD, 3, 1, LEVELS, 7);
        send_event(OP_ADD, 16'hFFFF, 0, 1, 1);
        send_event(OP_ADD, 16'(ORDERS), 0, 1, 1);
        send_event(OP_QUERY, 16'hFFFF, 0, 0, 0);
        send_event(OP_QUERY, 0, 1, LEVELS, 0);
        send_event(OP_MODIFY, 0, 1, 3, 9);
        send_event(OP_MODIFY, 1, 0, 32'hFFFF_FFFF, 9);
        send_event(OP_MODIFY, 9, 0, 3, 9);
        send_event(OP_CANCEL, 2, 0, 0, 0);
        send_event(OP_CANCEL, 2, 0, 0, 0);
        send_event(OP_CANCEL, 16'(ORDERS - 1), 0, 0, 0);
        send_event(3'd5, 0, 1, 0, 0);
        send_event(3'd7, 16'hFFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(OP_CLEAR, 0, 0, 0, 0);
        send_event(OP_ADD, 4, 0, 0, 0);
        send_event(OP_QUERY, 0, 0, 0, 0);

        set_base(32'hFFFF_FFFF - LEVELS + 1);
        send_event(OP_ADD, 5, 1, 32'hFFFF_FFFF, 3);
        send_event(OP_ADD, 6, 0, 32'hFFFF_FFFF - LEVELS + 1, 3);
        send_event(OP_QUERY, 0, 1, 32'hFFFF_FFFF, 0);
        send_event(OP_QUERY, 0, 0, 0, 0);
        random_phase(300, 64);

        set_base(32'd1000);
        hold_off = 1;
        random_phase(500, 48);
        set_base($urandom);
        random_phase(500, 5000);
        set_base(32'd0);
        random_phase(560, 32);

        in_valid <= 0;
        waited = 0;
        while (quotes_pending != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2*LEVELS*2 + 50) @(posedge clk);
        if (fail_count == 0 && quotes_pending == 0)
            $display("tb_limit_order_book_levels_unit: PASS");
        else
            $display("tb_limit_order_book_levels_unit: FAIL");
        $finish;
    end

    initial
    begin
        #500ms;
        $display("tb_limit_order_book_levels_unit: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/lobl_pkg.sv
design/limit_order_book_levels_unit.sv
tb/sv/lobl_book_checker.sv
tb/sv/tb_limit_order_book_levels_unit.sv
